>>> hdl/sabs_pkg.sv
// ----------------------------------------------------------------------------
// sabs_pkg
// Shared types and constants of the sorted-table binary search block.
// ----------------------------------------------------------------------------
package sabs_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = 10;
	localparam int LEN_W  = 11;
	localparam int DATA_W = 32;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic [ADDR_W-1:0]        entry_index;
		logic signed [DATA_W-1:0] value;
	} in_beat_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] position;
	} out_beat_t;

	typedef struct packed {
		logic                     wr_en;
		logic                     rd_en;
		logic [ADDR_W-1:0]        addr;
		logic signed [DATA_W-1:0] wdata;
	} mem_req_t;

endpackage

>>> hdl/sabs_store.sv
// ----------------------------------------------------------------------------
// sabs_store
// Single-port table memory, one access per cycle, read data registered.
// ----------------------------------------------------------------------------
module sabs_store (
	input  logic                              clk,
	input  sabs_pkg::mem_req_t                req,
	output logic signed [sabs_pkg::DATA_W-1:0] rdata
);

	logic signed [sabs_pkg::DATA_W-1:0] mem [sabs_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

>>> hdl/sabs_engine.sv
// ----------------------------------------------------------------------------
// sabs_engine
// Search sequencer that also issues write beats: one table probe per cycle, window kept as [lo, hi).
// ----------------------------------------------------------------------------
module sabs_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [sabs_pkg::LEN_W-1:0]         span,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  sabs_pkg::in_beat_t                 in_beat,
	output logic                               out_valid,
	input  logic                               out_stall,
	output sabs_pkg::out_beat_t                out_beat,
	output sabs_pkg::mem_req_t                 mem_req,
	input  logic signed [sabs_pkg::DATA_W-1:0] mem_rdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                         state_q;
	logic [sabs_pkg::LEN_W-1:0]         lo_q;
	logic [sabs_pkg::LEN_W-1:0]         hi_q;
	logic [sabs_pkg::ADDR_W-1:0]        mid_q;
	logic signed [sabs_pkg::DATA_W-1:0] key_q;
	logic                               res_found_q;
	logic [sabs_pkg::ADDR_W-1:0]        res_pos_q;
	logic                               out_valid_q;
	sabs_pkg::out_beat_t                out_beat_q;

	logic                               accept;
	logic                               start;
	logic [sabs_pkg::LEN_W-1:0]         span_m1;
	logic [sabs_pkg::ADDR_W-1:0]        mid0;
	logic                               cmp_eq;
	logic [sabs_pkg::LEN_W-1:0]         lo_n;
	logic [sabs_pkg::LEN_W-1:0]         hi_n;
	logic [sabs_pkg::LEN_W:0]           mid_sum;
	logic [sabs_pkg::ADDR_W-1:0]        mid_n;
	logic                               more;
	logic                               out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign start     = accept && (in_beat.cmd == sabs_pkg::CMD_SEARCH);
	assign span_m1   = span - sabs_pkg::LEN_W'(1);
	assign mid0      = span_m1[sabs_pkg::ADDR_W:1];
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

	always_comb begin
		cmp_eq = (mem_rdata == key_q);
		if (mem_rdata < key_q) begin
			lo_n = sabs_pkg::LEN_W'({1'b0, mid_q}) + sabs_pkg::LEN_W'(1);
			hi_n = hi_q;
		end else begin
			lo_n = lo_q;
			hi_n = sabs_pkg::LEN_W'({1'b0, mid_q});
		end
		mid_sum = {1'b0, lo_n} + {1'b0, hi_n} - (sabs_pkg::LEN_W+1)'(1);
		mid_n   = mid_sum[sabs_pkg::ADDR_W:1];
		more    = (lo_n < hi_n);
	end

	always_comb begin
		mem_req.wr_en = 1'b0;
		mem_req.rd_en = 1'b0;
		mem_req.addr  = in_beat.entry_index;
		mem_req.wdata = in_beat.value;
		if (accept && (in_beat.cmd == sabs_pkg::CMD_WRITE)) begin
			mem_req.wr_en = 1'b1;
		end else if (start && (span != '0)) begin
			mem_req.rd_en = 1'b1;
			mem_req.addr  = mid0;
		end else if ((state_q == S_CMP) && !cmp_eq && more) begin
			mem_req.rd_en = 1'b1;
			mem_req.addr  = mid_n;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (span != '0) ? S_CMP : S_DONE;
					end
				end
				S_CMP: begin
					if (cmp_eq || !more) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					key_q       <= in_beat.value;
					lo_q        <= '0;
					hi_q        <= span;
					mid_q       <= mid0;
					res_found_q <= 1'b0;
					res_pos_q   <= '0;
				end
			end
			S_CMP: begin
				if (cmp_eq) begin
					res_found_q <= 1'b1;
					res_pos_q   <= mid_q;
				end else begin
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					mid_q <= mid_n;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_beat_q.found    <= res_found_q;
					out_beat_q.position <= res_pos_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hdl/sorted_array_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_array_binary_search_top
// Sorted table of signed words with write and binary search beats.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  in       | sink      | in_valid / in_stall     | in_beat  (cmd, entry_index, value)
//  out      | source    | out_valid / out_stall   | out_beat (found, position)
//  cfg      | sink      | cfg_wr_en               | cfg_wr_data (active_length)
//
//  a write beat does not stall; the next beat is accepted in the following cycle
//  a search probes the single-port table at one probe per cycle
//  (at most 11 probes for 1024 entries) and then loads the result; an
//  empty search skips the probes and loads the result directly
//  in_stall is high from a search beat until its result is loaded, which waits
//  while an earlier result is still stalled
//  table contents are undefined after reset; active_length resets to 0
// ----------------------------------------------------------------------------
module sorted_array_binary_search_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [sabs_pkg::LEN_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  sabs_pkg::in_beat_t         in_beat,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sabs_pkg::out_beat_t        out_beat
);

	localparam logic [sabs_pkg::LEN_W-1:0] DEPTH_LEN = sabs_pkg::LEN_W'(sabs_pkg::DEPTH);

	logic [sabs_pkg::LEN_W-1:0]         active_length_q;
	logic [sabs_pkg::LEN_W-1:0]         span;
	sabs_pkg::mem_req_t                 mem_req;
	logic signed [sabs_pkg::DATA_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_length_q <= '0;
		end else if (cfg_wr_en) begin
			active_length_q <= cfg_wr_data;
		end
	end

	// lengths beyond the table saturate
	assign span = (active_length_q > DEPTH_LEN) ? DEPTH_LEN : active_length_q;

	sabs_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.span      (span),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	sabs_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

>>> hdl/sabs_checker.sv
// ----------------------------------------------------------------------------
// sabs_checker
// Port-level checks of the binary search block, bound to the top level.
// ----------------------------------------------------------------------------
module sabs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_wr_en,
	input logic [sabs_pkg::LEN_W-1:0] cfg_wr_data,
	input logic                       in_valid,
	input logic                       in_stall,
	input sabs_pkg::in_beat_t         in_beat,
	input logic                       out_valid,
	input logic                       out_stall,
	input sabs_pkg::out_beat_t        out_beat
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_beat))
		else $error("out beat changed while stalled");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_beat.found |-> out_beat.position == '0)
		else $error("miss with nonzero position");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_beat.cmd == sabs_pkg::CMD_SEARCH |=> in_stall)
		else $error("beat accepted during a search");

	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |-> !$isunknown(cfg_wr_data))
		else $error("length write with unknown data");

endmodule

bind sorted_array_binary_search_top sabs_checker u_sabs_checker (.*);
